/* hw/rtl/shrp_pkg.sv */
`default_nettype none

package shrp_pkg;

  // Default channel width of one color component
  localparam int COLOUR_BITS_DEF = 10;

  // Reciprocal of three: floor(x * 683 / 2048) == x / 3 for every x below 2048
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  // Weight of the center tap in the sharpen kernel
  localparam int CENTER_GAIN = 5;

  // Pixel layout: three color channels per pixel, three rows per column
  localparam int CHANNELS = 3;
  localparam int ROWS     = 3;

  // Enables for the two merge registers
  typedef struct packed {
    logic mag_en;
    logic out_en;
  } merge_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/shrp_lane.sv */
`default_nettype none

module shrp_lane #(
  parameter int COLOUR_BITS = shrp_pkg::COLOUR_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [COLOUR_BITS-1:0]        center,
  input  wire logic [COLOUR_BITS-1:0]        up,
  input  wire logic [COLOUR_BITS-1:0]        down,
  input  wire logic [COLOUR_BITS-1:0]        left_px,
  input  wire logic [COLOUR_BITS-1:0]        right_px,
  output logic signed [COLOUR_BITS+3:0]      lane_r
);
  import shrp_pkg::*;

  localparam int LW = COLOUR_BITS + 4;

  logic signed [LW-1:0] lane_nxt;
  logic        [LW-1:0] cz, uz, dz, lz, rz;

  // Apply the sharpen kernel to one channel, in two's complement of LW bits
  always_comb begin
    cz = {4'b0000, center};
    uz = {4'b0000, up};
    dz = {4'b0000, down};
    lz = {4'b0000, left_px};
    rz = {4'b0000, right_px};
    lane_nxt = $signed(cz * LW'(CENTER_GAIN) - uz - dz - lz - rz);
  end

  // Hold the lane result for the merge stage
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/shrp_merge.sv */
`default_nettype none

module shrp_merge #(
  parameter int COLOUR_BITS = shrp_pkg::COLOUR_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire shrp_pkg::merge_ctl_t        ctl,
  input  wire logic signed [COLOUR_BITS+3:0] lane_red,
  input  wire logic signed [COLOUR_BITS+3:0] lane_green,
  input  wire logic signed [COLOUR_BITS+3:0] lane_blue,
  output logic [COLOUR_BITS-1:0]           gray_r
);
  import shrp_pkg::*;

  localparam int SW = COLOUR_BITS + 6;
  localparam int PW = COLOUR_BITS + DIV3_SHIFT;
  localparam logic [SW-1:0] MAXV = SW'((1 << COLOUR_BITS) - 1);

  logic signed [SW-1:0]    sum;
  logic        [SW-1:0]    mag;
  logic [COLOUR_BITS-1:0]  mag_nxt;
  logic [COLOUR_BITS-1:0]  mag_r;
  logic [PW-1:0]           prod;
  logic [COLOUR_BITS-1:0]  gray_nxt;

  // Add the lanes, take the magnitude and clamp it at the largest color value
  always_comb begin
    sum = SW'(lane_red) + SW'(lane_green) + SW'(lane_blue);
    mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
    if (mag > MAXV) begin
      mag_nxt = MAXV[COLOUR_BITS-1:0];
    end else begin
      mag_nxt = mag[COLOUR_BITS-1:0];
    end
  end

  // Divide by three through the reciprocal
  always_comb begin
    prod     = PW'(mag_r) * PW'(DIV3_MUL);
    gray_nxt = prod[DIV3_SHIFT +: COLOUR_BITS];
  end

  always_ff @(posedge clk) begin
    if (ctl.mag_en) begin
      mag_r <= mag_nxt;
    end
    if (ctl.out_en) begin
      gray_r <= gray_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sharpen_3x3_gray_filter_unit.sv */
// 3x3 sharpen filter over an RGB column stream with gray output.
//
// Input channel (in_*): one item is one column of three stacked RGB pixels,
// row0 in the lowest bits of in_tdata. Output channel (out_*): one item per
// input item, the gray level copied into red, green and blue.
// The block keeps the two previous columns, so every item sees a full 3x3
// window; three channel lanes apply the kernel 0,-1,0/-1,5,-1/0,-1,0 side by
// side, and a merge stage adds them, takes the magnitude, clamps at the top
// color value and divides by three.
// An accepted item passes the lane, magnitude and output registers before it
// reaches out_tvalid. Throughput: one item per cycle while the receiver does not stall.
// Reset (rst_n low, synchronous) empties the pipeline and fills the window
// with zero pixels, so the first two results use zero columns.
// When the receiver stalls, out_tdata holds; the pipeline keeps accepting
// until its three registers are full, then in_tready drops.
`default_nettype none

module sharpen_3x3_gray_filter_unit #(
  parameter int COLOUR_BITS = shrp_pkg::COLOUR_BITS_DEF,
  localparam int PIX_W      = 3 * COLOUR_BITS,
  localparam int IN_W       = ((3 * PIX_W + 7) / 8) * 8,
  localparam int OUT_W      = ((PIX_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // row0_pixel, row1_pixel, row2_pixel, zero pad
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // gray_pixel, zero pad
);
  import shrp_pkg::*;

  localparam int LW = COLOUR_BITS + 4;

  logic             in_fire;
  logic             en1, en2, en3;
  logic             v1_r, v2_r, out_valid_r;
  logic [PIX_W-1:0] new_col [ROWS];
  logic [PIX_W-1:0] col1_r  [ROWS];
  logic [PIX_W-1:0] col2_r  [ROWS];
  logic signed [LW-1:0] lane_res [CHANNELS];
  logic [COLOUR_BITS-1:0] gray;
  merge_ctl_t       mctl;

  // Advance each stage when the one after it has room
  assign en3       = !out_valid_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_fire   = in_tvalid && in_tready;

  assign mctl.mag_en = en2;
  assign mctl.out_en = en3;

  // Unpack the incoming column
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      new_col[r] = in_tdata[r*PIX_W +: PIX_W];
    end
  end

  // Track valid items through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_tvalid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Shift the window by one column on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        col1_r[r] <= '0;
        col2_r[r] <= '0;
      end
    end else if (in_fire) begin
      for (int r = 0; r < ROWS; r++) begin
        col1_r[r] <= new_col[r];
        col2_r[r] <= col1_r[r];
      end
    end
  end

  // One lane per color channel; the middle column is the kernel center
  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    shrp_lane #(
      .COLOUR_BITS (COLOUR_BITS)
    ) u_lane (
      .clk      (clk),
      .en       (en1),
      .center   (col1_r[1][k*COLOUR_BITS +: COLOUR_BITS]),
      .up       (col1_r[0][k*COLOUR_BITS +: COLOUR_BITS]),
      .down     (col1_r[2][k*COLOUR_BITS +: COLOUR_BITS]),
      .left_px  (new_col[1][k*COLOUR_BITS +: COLOUR_BITS]),
      .right_px (col2_r[1][k*COLOUR_BITS +: COLOUR_BITS]),
      .lane_r   (lane_res[k])
    );
  end

  shrp_merge #(
    .COLOUR_BITS (COLOUR_BITS)
  ) u_merge (
    .clk        (clk),
    .ctl        (mctl),
    .lane_red   (lane_res[2]),
    .lane_green (lane_res[1]),
    .lane_blue  (lane_res[0]),
    .gray_r     (gray)
  );

  // Replicate the gray level into all three channels
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({gray, gray, gray});

endmodule

`default_nettype wire

/* hw/rtl/shrp_checker.sv */
`default_nettype none

module shrp_checker #(
  parameter int COLOUR_BITS = shrp_pkg::COLOUR_BITS_DEF,
  localparam int PIX_W      = 3 * COLOUR_BITS,
  localparam int OUT_W      = ((PIX_W + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  import shrp_pkg::*;

  localparam logic [COLOUR_BITS-1:0] GRAY_MAX =
    COLOUR_BITS'(((1 << COLOUR_BITS) - 1) / 3);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // All three channels carry the same gray level
  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[2*COLOUR_BITS +: COLOUR_BITS] == out_tdata[0 +: COLOUR_BITS] &&
      out_tdata[COLOUR_BITS +: COLOUR_BITS] == out_tdata[0 +: COLOUR_BITS])
    else $error("gray channels differ");

  // Clamp then divide by three bounds the gray level
  a_gray_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0 +: COLOUR_BITS] <= GRAY_MAX)
    else $error("gray level above clamp / 3");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind sharpen_3x3_gray_filter_unit shrp_checker #(
  .COLOUR_BITS (COLOUR_BITS)
) u_shrp_checker (.*);

`default_nettype wire
